// ===== design/i2c_master_byte_engine_core_macros.svh =====
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MBE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MBE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/i2c_mbe_pkg.sv =====
package i2c_mbe_pkg;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_ST_A    = 4'd1,
		PH_ST_B    = 4'd2,
		PH_SP_A    = 4'd3,
		PH_SP_B    = 4'd4,
		PH_WB_LOW  = 4'd5,
		PH_WB_HIGH = 4'd6,
		PH_WB_TAIL = 4'd7,
		PH_AK_REL  = 4'd8,
		PH_AK_POLL = 4'd9,
		PH_RB_LOW  = 4'd10,
		PH_RB_HIGH = 4'd11,
		PH_AN_LOW  = 4'd12,
		PH_AN_HIGH = 4'd13
	} phase_t;

	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;

	localparam logic [1:0] REG_EDGE_HOLD   = 2'd0;
	localparam logic [1:0] REG_HALF_BIT    = 2'd1;
	localparam logic [1:0] REG_ACK_TIMEOUT = 2'd2;

	localparam logic [7:0] EDGE_HOLD_RST   = 8'd4;
	localparam logic [7:0] HALF_BIT_RST    = 8'd2;
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
	localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic [7:0] edge_hold_ticks;
		logic [7:0] half_bit_ticks;
		logic [7:0] ack_timeout_polls;
	} cfg_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_missing;
	} res_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] tick_count;
		logic [3:0] bit_index;
		logic [7:0] shift_reg;
		logic [7:0] poll_count;
		logic       scl_reg;
		logic       sda_reg;
		logic       ack_choice;
		logic       error_flag;
		logic [7:0] rx_hold;
	} seq_st_t;

	function automatic logic [7:0] at_least_one(input logic [7:0] v);
		return (v == 8'd0) ? 8'd1 : v;
	endfunction

endpackage

// ===== design/i2c_master_byte_engine_core.sv =====
// I2C master byte sequencer. Every transfer on the s_ channel is one bus tick:
// s_tuser carries the command (none, start, stop, write byte, read byte) and
// s_tdata the byte to send, the ACK choice for reads and the sampled SDA level.
// Every accepted tick yields exactly one m_ transfer with the SCL and SDA drive
// for that tick, busy, a one-tick done pulse, the last read byte and the
// missing-acknowledge flag. Commands that arrive while busy are dropped.
// The input register holds each tick, then the sequencer update is captured into
// the result register; throughput is one tick per cycle while m_tready does not
// stall the result register, as the sequencer updates its state on every step.
// The cfg channel writes the edge hold, half-bit and ack timeout tick counts;
// it is always ready and should only be used while the sequencer is idle.
// Reset returns the sequencer to idle with SCL and SDA released, rx_byte 0 and
// the registers at 4, 2 and 250. When m_tready is low the result register and
// the input register both hold, s_tready drops once both are full, and no
// tick is lost or repeated.
`include "i2c_master_byte_engine_core_macros.svh"

module i2c_master_byte_engine_core
	import i2c_mbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,  // cmd
	input  logic [15:0] s_tdata,  // tx_byte[7:0], send_ack[8], sda_in[9], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	// scl_level[0], sda_level[1], busy_res[2], done_res[3], rx_byte[11:4],
	// ack_missing[12], zero pad
	output logic [15:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic  v_s1;
	item_t item_s1;
	logic  out_v_q;
	res_t  res_q;
	res_t  res_d;
	cfg_t  cfg_q;
	logic  adv;

	assign adv       = !out_v_q || m_tready;
	assign s_tready  = !v_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.edge_hold_ticks   <= EDGE_HOLD_RST;
			cfg_q.half_bit_ticks    <= HALF_BIT_RST;
			cfg_q.ack_timeout_polls <= ACK_TIMEOUT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_EDGE_HOLD:   cfg_q.edge_hold_ticks   <= cfg_data;
				REG_HALF_BIT:    cfg_q.half_bit_ticks    <= cfg_data;
				REG_ACK_TIMEOUT: cfg_q.ack_timeout_polls <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.cmd      <= s_tuser;
			item_s1.tx_byte  <= s_tdata[7:0];
			item_s1.send_ack <= s_tdata[8];
			item_s1.sda_in   <= s_tdata[9];
		end
	end

	i2c_mbe_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (v_s1 && adv),
		.item    (item_s1),
		.cfg     (cfg_q),
		.res     (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {3'd0, res_q.ack_missing, res_q.rx_byte, res_q.done_res,
		res_q.busy_res, res_q.sda_level, res_q.scl_level};

	`MBE_ASSERT_NOW(a_done_not_busy, m_tvalid && m_tdata[3], !m_tdata[2], "done while busy")
	`MBE_ASSERT_NEXT(a_s1_holds, v_s1 && !adv, v_s1, "queued tick dropped")
	`MBE_ASSERT_NEXT(a_step_to_out, v_s1 && adv, m_tvalid, "tick produced no result")

endmodule

// ===== design/i2c_mbe_seq.sv =====
module i2c_mbe_seq
	import i2c_mbe_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step_en,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res
);

	seq_st_t st_q;
	seq_st_t nx;
	logic    done_d;
	logic [3:0] nbit;
	logic [7:0] nshift;

	always_comb begin
		nx     = st_q;
		done_d = 1'b0;
		nbit   = st_q.bit_index + 4'd1;
		nshift = 8'd0;
		if (st_q.phase == PH_IDLE) begin
			if (item.cmd >= CMD_START && item.cmd <= CMD_READ) begin
				nx.error_flag = 1'b0;
				nx.bit_index  = 4'd0;
				case (item.cmd)
					CMD_START: begin
						nx.phase = PH_ST_A; nx.scl_reg = 1'b1; nx.sda_reg = 1'b1;
						nx.tick_count = at_least_one(cfg.edge_hold_ticks);
					end
					CMD_STOP: begin
						nx.phase = PH_SP_A; nx.scl_reg = 1'b0; nx.sda_reg = 1'b0;
						nx.tick_count = at_least_one(cfg.edge_hold_ticks);
					end
					CMD_WRITE: begin
						nx.shift_reg = item.tx_byte;
						nx.phase = PH_WB_LOW; nx.scl_reg = 1'b0; nx.sda_reg = item.tx_byte[7];
						nx.tick_count = at_least_one(cfg.half_bit_ticks);
					end
					default: begin
						nx.ack_choice = item.send_ack;
						nx.shift_reg  = 8'd0;
						nx.phase = PH_RB_LOW; nx.scl_reg = 1'b0; nx.sda_reg = 1'b1;
						nx.tick_count = at_least_one(cfg.half_bit_ticks);
					end
				endcase
			end
		end else if (st_q.phase == PH_AK_POLL) begin
			if (!item.sda_in) begin
				nx.scl_reg    = 1'b0;
				nx.poll_count = 8'd0;
				nx.phase      = PH_IDLE;
				nx.tick_count = 8'd0;
				done_d        = 1'b1;
			end else if (st_q.poll_count >= cfg.ack_timeout_polls) begin
				nx.error_flag = 1'b1;
				nx.poll_count = 8'd0;
				nx.phase = PH_SP_A; nx.scl_reg = 1'b0; nx.sda_reg = 1'b0;
				nx.tick_count = at_least_one(cfg.edge_hold_ticks);
			end else begin
				nx.poll_count = st_q.poll_count + 8'd1;
			end
		end else if (st_q.tick_count > 8'd1) begin
			nx.tick_count = st_q.tick_count - 8'd1;
		end else begin
			case (st_q.phase)
				PH_ST_A: begin
					nx.phase = PH_ST_B; nx.scl_reg = 1'b1; nx.sda_reg = 1'b0;
					nx.tick_count = at_least_one(cfg.edge_hold_ticks);
				end
				PH_ST_B: begin
					nx.scl_reg = 1'b0;
					nx.phase = PH_IDLE; nx.tick_count = 8'd0; done_d = 1'b1;
				end
				PH_SP_A: begin
					nx.phase = PH_SP_B; nx.scl_reg = 1'b1; nx.sda_reg = 1'b1;
					nx.tick_count = at_least_one(cfg.edge_hold_ticks);
				end
				PH_WB_LOW: begin
					nx.phase = PH_WB_HIGH; nx.scl_reg = 1'b1;
					nx.tick_count = at_least_one(cfg.half_bit_ticks);
				end
				PH_WB_HIGH: begin
					nx.phase = PH_WB_TAIL; nx.scl_reg = 1'b0;
					nx.tick_count = at_least_one(cfg.half_bit_ticks);
				end
				PH_WB_TAIL: begin
					nshift       = {st_q.shift_reg[6:0], 1'b0};
					nx.shift_reg = nshift;
					nx.bit_index = nbit;
					nx.scl_reg   = 1'b0;
					if (nbit < BITS_PER_BYTE) begin
						nx.phase = PH_WB_LOW; nx.sda_reg = nshift[7];
						nx.tick_count = at_least_one(cfg.half_bit_ticks);
					end else begin
						nx.phase = PH_AK_REL; nx.sda_reg = 1'b1; nx.tick_count = 8'd1;
					end
				end
				PH_AK_REL: begin
					nx.phase = PH_AK_POLL; nx.scl_reg = 1'b1; nx.sda_reg = 1'b1;
					nx.tick_count = 8'd1;
					nx.poll_count = 8'd0;
				end
				PH_RB_LOW: begin
					nx.phase = PH_RB_HIGH; nx.scl_reg = 1'b1; nx.sda_reg = 1'b1;
					nx.tick_count = at_least_one(cfg.half_bit_ticks);
				end
				PH_RB_HIGH: begin
					nx.shift_reg = {st_q.shift_reg[6:0], item.sda_in};
					nx.bit_index = nbit;
					nx.scl_reg   = 1'b0;
					nx.tick_count = at_least_one(cfg.half_bit_ticks);
					if (nbit < BITS_PER_BYTE) begin
						nx.phase = PH_RB_LOW; nx.sda_reg = 1'b1;
					end else begin
						nx.phase = PH_AN_LOW; nx.sda_reg = ~st_q.ack_choice;
					end
				end
				PH_AN_LOW: begin
					nx.phase = PH_AN_HIGH; nx.scl_reg = 1'b1;
					nx.tick_count = at_least_one(cfg.half_bit_ticks);
				end
				PH_AN_HIGH: begin
					nx.scl_reg = 1'b0;
					nx.rx_hold = st_q.shift_reg;
					nx.phase = PH_IDLE; nx.tick_count = 8'd0; done_d = 1'b1;
				end
				default: begin
					nx.phase = PH_IDLE; nx.tick_count = 8'd0; done_d = 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		res.scl_level   = nx.scl_reg;
		res.sda_level   = nx.sda_reg;
		res.busy_res    = (nx.phase != PH_IDLE);
		res.done_res    = done_d;
		res.rx_byte     = nx.rx_hold;
		res.ack_missing = nx.error_flag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase      <= PH_IDLE;
			st_q.tick_count <= 8'd0;
			st_q.bit_index  <= 4'd0;
			st_q.shift_reg  <= 8'd0;
			st_q.poll_count <= 8'd0;
			st_q.scl_reg    <= 1'b1;
			st_q.sda_reg    <= 1'b1;
			st_q.ack_choice <= 1'b0;
			st_q.error_flag <= 1'b0;
			st_q.rx_hold    <= 8'd0;
		end else if (step_en) begin
			st_q <= nx;
		end
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import i2c_mbe_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int TOTAL_TICKS = 1350;
	localparam logic [2:0] CMD_RSVD_A = 3'd5;
	localparam logic [2:0] CMD_RSVD_B = 3'd6;
	localparam logic [2:0] CMD_RSVD_C = 3'd7;
	localparam logic [9:0] ACK_NEVER = 10'd1000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [2:0]  s_tuser;   // cmd
	logic [15:0] s_tdata;   // tx_byte[7:0], send_ack[8], sda_in[9], zero pad
	logic        m_tvalid;
	logic        m_tready;
	// scl_level[0], sda_level[1], busy_res[2], done_res[3], rx_byte[11:4],
	// ack_missing[12], zero pad
	logic [15:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	i2c_master_byte_engine_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// directed command rows; pin marks rows whose final tick has a known rx/error
	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] tx;
		logic       ack;
		logic [7:0] pat;
		logic [9:0] ack_wait;
		logic       noisy;
		logic       pin;
		logic [7:0] rx;
		logic       err;
	} dir_row_t;

	localparam int N_DIR = 17;
	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		'{CMD_NONE,   8'h00, 1'b0, 8'h00, 10'd0,   1'b0, 1'b1, 8'h00, 1'b0},
		'{CMD_RSVD_A, 8'hFF, 1'b1, 8'h00, 10'd0,   1'b0, 1'b1, 8'h00, 1'b0},
		'{CMD_RSVD_B, 8'h55, 1'b0, 8'h00, 10'd0,   1'b0, 1'b1, 8'h00, 1'b0},
		'{CMD_RSVD_C, 8'hAA, 1'b1, 8'h00, 10'd0,   1'b0, 1'b1, 8'h00, 1'b0},
		'{CMD_START,  8'h00, 1'b0, 8'h00, 10'd0,   1'b0, 1'b0, 8'h00, 1'b0},
		'{CMD_WRITE,  8'h00, 1'b0, 8'h00, 10'd0,   1'b0, 1'b0, 8'h00, 1'b0},
		'{CMD_WRITE,  8'hFF, 1'b1, 8'h00, 10'd3,   1'b0, 1'b0, 8'h00, 1'b0},
		'{CMD_WRITE,  8'hA5, 1'b0, 8'h00, 10'd12,  1'b0, 1'b1, 8'h00, 1'b0},
		'{CMD_WRITE,  8'h5A, 1'b0, 8'h00, ACK_NEVER, 1'b0, 1'b1, 8'h00, 1'b1},
		'{CMD_NONE,   8'h00, 1'b0, 8'h00, 10'd0,   1'b0, 1'b1, 8'h00, 1'b1},
		'{CMD_START,  8'h00, 1'b0, 8'h00, 10'd0,   1'b1, 1'b0, 8'h00, 1'b0},
		'{CMD_READ,   8'h00, 1'b0, 8'hFF, 10'd0,   1'b0, 1'b1, 8'hFF, 1'b0},
		'{CMD_READ,   8'h00, 1'b1, 8'h00, 10'd0,   1'b0, 1'b1, 8'h00, 1'b0},
		'{CMD_READ,   8'h00, 1'b1, 8'h96, 10'd0,   1'b0, 1'b1, 8'h96, 1'b0},
		'{CMD_STOP,   8'h00, 1'b0, 8'h00, 10'd0,   1'b0, 1'b1, 8'h96, 1'b0},
		'{CMD_WRITE,  8'h81, 1'b0, 8'h00, 10'd1,   1'b1, 1'b0, 8'h00, 1'b0},
		'{CMD_STOP,   8'h00, 1'b0, 8'h00, 10'd0,   1'b1, 1'b0, 8'h00, 1'b0}
	};

	seq_st_t seq;
	cfg_t    regs;
	logic    done_pulse;
	res_t    line_expect [$];

	int errs;
	int tick_total;
	int compared;
	int settings_used;
	int ack_timeouts;
	int cmd_cnt [8];
	int gap_pct;
	int stall_pct;
	int hold_cnt;
	bit hold_req;
	int stall_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void enter(input phase_t ph, input logic scl, input logic sda,
			input logic [7:0] cnt);
		seq.phase = ph;
		seq.scl_reg = scl;
		seq.sda_reg = sda;
		seq.tick_count = (cnt == 8'd0) ? 8'd1 : cnt;
	endfunction

	function automatic void close_cmd();
		seq.phase = PH_IDLE;
		seq.tick_count = 8'd0;
		done_pulse = 1'b1;
	endfunction

	// one bus tick of the sequencer
	function automatic res_t bus_tick(input item_t it);
		res_t r;
		logic [7:0] e;
		logic [7:0] h;
		e = regs.edge_hold_ticks;
		h = regs.half_bit_ticks;
		done_pulse = 1'b0;
		if (seq.phase == PH_IDLE) begin
			if (it.cmd >= CMD_START && it.cmd <= CMD_READ) begin
				cmd_cnt[it.cmd]++;
				seq.error_flag = 1'b0;
				seq.bit_index = 4'd0;
				case (it.cmd)
					CMD_START: enter(PH_ST_A, 1'b1, 1'b1, e);
					CMD_STOP: enter(PH_SP_A, 1'b0, 1'b0, e);
					CMD_WRITE: begin
						seq.shift_reg = it.tx_byte;
						enter(PH_WB_LOW, 1'b0, it.tx_byte[7], h);
					end
					default: begin
						seq.ack_choice = it.send_ack;
						seq.shift_reg = 8'd0;
						enter(PH_RB_LOW, 1'b0, 1'b1, h);
					end
				endcase
			end
		end else if (seq.phase == PH_AK_POLL) begin
			if (!it.sda_in) begin
				seq.scl_reg = 1'b0;
				seq.poll_count = 8'd0;
				close_cmd();
			end else if (seq.poll_count >= regs.ack_timeout_polls) begin
				ack_timeouts++;
				seq.error_flag = 1'b1;
				seq.poll_count = 8'd0;
				enter(PH_SP_A, 1'b0, 1'b0, e);
			end else begin
				seq.poll_count = seq.poll_count + 8'd1;
			end
		end else if (seq.tick_count > 8'd1) begin
			seq.tick_count = seq.tick_count - 8'd1;
		end else begin
			case (seq.phase)
				PH_ST_A: enter(PH_ST_B, 1'b1, 1'b0, e);
				PH_ST_B: begin
					seq.scl_reg = 1'b0;
					close_cmd();
				end
				PH_SP_A: enter(PH_SP_B, 1'b1, 1'b1, e);
				PH_SP_B: close_cmd();
				PH_WB_LOW: enter(PH_WB_HIGH, 1'b1, seq.sda_reg, h);
				PH_WB_HIGH: enter(PH_WB_TAIL, 1'b0, seq.sda_reg, h);
				PH_WB_TAIL: begin
					seq.shift_reg = {seq.shift_reg[6:0], 1'b0};
					seq.bit_index = seq.bit_index + 4'd1;
					if (seq.bit_index < BITS_PER_BYTE)
						enter(PH_WB_LOW, 1'b0, seq.shift_reg[7], h);
					else
						enter(PH_AK_REL, 1'b0, 1'b1, 8'd1);
				end
				PH_AK_REL: begin
					enter(PH_AK_POLL, 1'b1, 1'b1, 8'd1);
					seq.poll_count = 8'd0;
				end
				PH_RB_LOW: enter(PH_RB_HIGH, 1'b1, 1'b1, h);
				PH_RB_HIGH: begin
					seq.shift_reg = {seq.shift_reg[6:0], it.sda_in};
					seq.bit_index = seq.bit_index + 4'd1;
					if (seq.bit_index < BITS_PER_BYTE)
						enter(PH_RB_LOW, 1'b0, 1'b1, h);
					else
						enter(PH_AN_LOW, 1'b0, !seq.ack_choice, h);
				end
				PH_AN_LOW: enter(PH_AN_HIGH, 1'b1, seq.sda_reg, h);
				PH_AN_HIGH: begin
					seq.scl_reg = 1'b0;
					seq.rx_hold = seq.shift_reg;
					close_cmd();
				end
				default: close_cmd();
			endcase
		end
		r.scl_level = seq.scl_reg;
		r.sda_level = seq.sda_reg;
		r.busy_res = (seq.phase != PH_IDLE);
		r.done_res = done_pulse;
		r.rx_byte = seq.rx_hold;
		r.ack_missing = seq.error_flag;
		return r;
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_tick(input item_t it, input bit pin, input logic [7:0] pin_rx,
			input logic pin_err);
		res_t r;
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.cmd;
		s_tdata <= {6'd0, it.sda_in, it.send_ack, it.tx_byte};
		do @(posedge clk); while (!s_tready);
		r = bus_tick(it);
		if (pin && !r.busy_res) begin
			r.rx_byte = pin_rx;
			r.ack_missing = pin_err;
		end
		line_expect.push_back(r);
		tick_total++;
		@(negedge clk);
	endtask

	// issue one command and keep ticking until the sequencer is idle again
	task automatic run_cmd(input logic [2:0] c, input logic [7:0] tx, input logic ack,
			input logic [7:0] pat, input int ack_wait, input bit noisy, input bit pin,
			input logic [7:0] pin_rx, input logic pin_err);
		item_t it;
		int polls;
		polls = 0;
		it.cmd = c;
		it.tx_byte = tx;
		it.send_ack = ack;
		it.sda_in = 1'($urandom_range(1));
		send_tick(it, pin, pin_rx, pin_err);
		while (seq.phase != PH_IDLE) begin
			it.cmd = (noisy && $urandom_range(3) == 0) ? 3'($urandom_range(7)) : CMD_NONE;
			it.tx_byte = 8'($urandom);
			it.send_ack = 1'($urandom_range(1));
			if (seq.phase == PH_AK_POLL) begin
				it.sda_in = (polls >= ack_wait) ? 1'b0 : 1'b1;
				polls++;
			end else if (seq.phase == PH_RB_HIGH) begin
				it.sda_in = pat[3'd7 - seq.bit_index[2:0]];
			end else begin
				it.sda_in = 1'($urandom_range(1));
			end
			send_tick(it, pin, pin_rx, pin_err);
		end
	endtask

	function automatic int pick_ack_wait();
		int t;
		int roll;
		t = int'(regs.ack_timeout_polls);
		roll = $urandom_range(99);
		if (roll < 10)
			return t + 1;
		if (roll < 16)
			return t;
		return $urandom_range(0, (t < 5) ? t : 5);
	endfunction

	task automatic rand_op(input logic [2:0] c, input bit noisy);
		run_cmd(c, 8'($urandom), 1'($urandom_range(1)), 8'($urandom), pick_ack_wait(),
			noisy, 1'b0, 8'd0, 1'b0);
	endtask

	// mostly well-formed transactions, some loose commands and bare ticks
	task automatic random_burst();
		bit noisy;
		repeat ($urandom_range(1, 3)) begin
			noisy = ($urandom_range(4) == 0);
			if ($urandom_range(99) < 80) begin
				rand_op(CMD_START, noisy);
				rand_op(CMD_WRITE, noisy);
				repeat ($urandom_range(1, 3))
					rand_op($urandom_range(1) ? CMD_WRITE : CMD_READ, noisy);
				if ($urandom_range(9) != 0)
					rand_op(CMD_STOP, noisy);
			end else begin
				repeat ($urandom_range(1, 4))
					rand_op(3'($urandom_range(7)), 1'b1);
			end
			repeat ($urandom_range(0, 3))
				rand_op(CMD_NONE, 1'b0);
		end
	endtask

	// all results back and pipeline empty before touching registers
	task automatic settle_bus();
		s_tvalid <= 1'b0;
		while (line_expect.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_EDGE_HOLD: regs.edge_hold_ticks = d;
			REG_HALF_BIT: regs.half_bit_ticks = d;
			REG_ACK_TIMEOUT: regs.ack_timeout_polls = d;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_cfg(input logic [7:0] e, input logic [7:0] h, input logic [7:0] t);
		write_reg(REG_EDGE_HOLD, e);
		write_reg(REG_HALF_BIT, h);
		write_reg(REG_ACK_TIMEOUT, t);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic set_mode(input int m);
		case (m % 4)
			0: begin gap_pct = 0; stall_pct = 0; end
			1: begin gap_pct = 59; stall_pct = 0; end
			2: begin gap_pct = 0; stall_pct = 59; end
			default: begin gap_pct = 31; stall_pct = 31; end
		endcase
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		hold_cnt = 0;
		forever begin
			@(negedge clk);
			if (hold_cnt > 0) begin
				m_tready <= 1'b0;
				hold_cnt--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = 80;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic void check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			errs++;
		end
	endfunction

	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (line_expect.size() == 0) begin
				$error("result transfer %04h with no tick outstanding", m_tdata);
				errs++;
			end else begin
				want = line_expect.pop_front();
				compared++;
				check_field("scl_level", 8'(want.scl_level), 8'(m_tdata[0]));
				check_field("sda_level", 8'(want.sda_level), 8'(m_tdata[1]));
				check_field("busy_res", 8'(want.busy_res), 8'(m_tdata[2]));
				check_field("done_res", 8'(want.done_res), 8'(m_tdata[3]));
				check_field("rx_byte", want.rx_byte, m_tdata[11:4]);
				check_field("ack_missing", 8'(want.ack_missing), 8'(m_tdata[12]));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("no transfer for %0d cycles", STALL_LIMIT);
				$display("FAIL i2c_master_byte_engine_core");
				$finish;
			end
		end
	end

	initial begin
		int ph;
		dir_row_t row;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = CMD_NONE;
		s_tdata = 16'd0;
		cfg_valid = 1'b0;
		cfg_index = REG_EDGE_HOLD;
		cfg_data = 8'd0;
		hold_req = 1'b0;
		stall_cycles = 0;
		errs = 0;
		tick_total = 0;
		compared = 0;
		settings_used = 1;
		ack_timeouts = 0;
		foreach (cmd_cnt[i]) cmd_cnt[i] = 0;
		seq = '0;
		seq.phase = PH_IDLE;
		seq.scl_reg = 1'b1;
		seq.sda_reg = 1'b1;
		regs.edge_hold_ticks = EDGE_HOLD_RST;
		regs.half_bit_ticks = HALF_BIT_RST;
		regs.ack_timeout_polls = ACK_TIMEOUT_RST;
		set_mode(0);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset defaults
		for (int i = 0; i < N_DIR; i++) begin
			row = DIR_ROWS[i];
			run_cmd(row.cmd, row.tx, row.ack, row.pat, int'(row.ack_wait), row.noisy,
				row.pin, row.rx, row.err);
		end
		settle_bus();

		// shortest timing, with the receiver held off while ticks keep coming
		set_cfg(8'd1, 8'd1, 8'd1);
		hold_req = 1'b1;
		random_burst();
		settle_bus();

		// zero counts; edge hold and half-bit counts behave as one
		set_mode(3);
		set_cfg(8'd0, 8'd0, 8'd0);
		random_burst();
		settle_bus();

		// random settings, sender gaps and receiver stalls
		ph = 1;
		while (ph < 3 || tick_total < TOTAL_TICKS) begin
			set_mode(ph);
			set_cfg(8'($urandom_range(1, 5)), 8'($urandom_range(1, 3)),
				($urandom_range(3) == 0) ? 8'($urandom_range(9, 60))
				: 8'($urandom_range(1, 8)));
			random_burst();
			settle_bus();
			ph++;
		end

		repeat (8) @(posedge clk);
		$display("%0d ticks under %0d register settings, %0d results checked",
			tick_total, settings_used, compared);
		$display("commands: %0d start, %0d stop, %0d write (%0d ack timeouts), %0d read",
			cmd_cnt[CMD_START], cmd_cnt[CMD_STOP], cmd_cnt[CMD_WRITE], ack_timeouts,
			cmd_cnt[CMD_READ]);
		if (errs == 0 && line_expect.size() == 0)
			$display("PASS i2c_master_byte_engine_core");
		else
			$display("FAIL i2c_master_byte_engine_core");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/i2c_mbe_pkg.sv
design/i2c_mbe_seq.sv
design/i2c_master_byte_engine_core.sv
test/tb.sv
